// ===== rtl/sbs_pkg.sv =====
// Shared types and constants of the sorted byte statistics block.
`timescale 1ns / 1ps
`default_nettype none

package sbs_pkg;

   localparam int CAPACITY_DEF = 64;

   typedef struct packed {
      logic [7:0] sample;
      logic       final_item;
   } req_type;

   typedef struct packed {
      logic [7:0] sorted_value;
      logic [7:0] minimum;
      logic [7:0] maximum;
      logic [7:0] mean;
      logic [7:0] median;
      logic       overflow;
      logic       run_end;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/sbs_ram.sv =====
// Generic single-clock RAM, one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/sorted_byte_statistics_core.sv =====
// Top level of the sorted byte statistics block: insertion sort in RAM plus statistics.
//
// Usage:
//   Bytes arrive on the req_ channel (valid/ready), one transaction per byte;
//   final_item marks the last byte of a set. Each byte is inserted into a RAM
//   that is kept in descending order. An insertion moves down every stored
//   entry smaller than the byte, then writes the byte: the RAM moves one
//   entry per cycle (one read, one write). req_ready is high only between
//   insertions and not while a set is being reported.
//   After the marked byte the block reads max, min and the two middle entries
//   (the same entry for an odd count), then divides the sum by the count in a
//   bit-serial divider over the SUM_W-bit sum (14 bits at the default capacity).
//   It then emits one rsp_ transaction per stored byte, largest first, each
//   read and then loaded into the output register; every result carries min,
//   max, mean, median and the overflow flag, and run_end marks the last one.
//   Bytes beyond CAPACITY are dropped and raise the overflow flag of the set.
//   A stalled receiver holds the output register and the emission pauses; the
//   last result of a run may still wait in the output register while the next
//   set is already being loaded.
//   Reset clears the count, sum, overflow flag, state and rsp_valid. The RAM
//   needs no clearing: only entries below the count are ever used.

`timescale 1ns / 1ps
`default_nettype none

module sorted_byte_statistics_core
   import sbs_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int SUM_W  = $clog2(CAPACITY * 255 + 1);
   localparam int DIV_W  = $clog2(SUM_W + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_PLACE,
      S_STAT,
      S_DIV,
      S_EMIT_RD,
      S_EMIT_LOAD
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               ovf_ff, ovf_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [7:0]         v_ff, v_in;
   logic               last_ff, last_in;
   logic [2:0]         stat_step_ff, stat_step_in;
   logic [DIV_W-1:0]   div_step_ff, div_step_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [7:0]         max_ff, max_in;
   logic [7:0]         min_ff, min_in;
   logic [7:0]         mid_ff, mid_in;
   logic [7:0]         median_ff, median_in;
   logic [7:0]         mean_ff, mean_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [SUM_W-1:0]   num_ff, num_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [7:0]         wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [7:0]         rd_data;

   logic [CNT_W:0]     rem_sh;
   logic               div_ge;
   logic               emit_last;
   logic [8:0]         mid_sum;

   sbs_ram #(
      .WIDTH (8),
      .DEPTH (CAPACITY)
   ) u_sbs_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // One restoring divider step: shift in the next dividend bit.
   assign rem_sh    = {rem_ff, num_ff[SUM_W-1]};
   assign div_ge    = (rem_sh >= {1'b0, count_ff});
   assign emit_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign mid_sum   = {1'b0, mid_ff} + {1'b0, rd_data};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      pos_in       = pos_ff;
      v_in         = v_ff;
      last_in      = last_ff;
      stat_step_in = stat_step_ff;
      div_step_in  = div_step_ff;
      idx_in       = idx_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      mid_in       = mid_ff;
      median_in    = median_ff;
      mean_in      = mean_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = v_ff;
      rd_addr      = '0;

      // Drop the held result once the receiver takes it.
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            // Prefetch the current tail entry for the first compare.
            rd_addr = ADDR_W'(count_ff - CNT_W'(1));
            if (req_valid) begin
               v_in    = req_data.sample;
               last_in = req_data.final_item;
               if (count_ff < CNT_W'(CAPACITY)) begin
                  pos_in   = ADDR_W'(count_ff);
                  state_in = (count_ff == '0) ? S_PLACE : S_SHIFT;
               end else begin
                  ovf_in = 1'b1;
                  if (req_data.final_item) begin
                     stat_step_in = '0;
                     state_in     = S_STAT;
                  end
               end
            end
         end

         S_SHIFT: begin
            // rd_data holds entry pos-1; move it down or place the byte here.
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            rd_addr = pos_ff - ADDR_W'(2);
            if (rd_data < v_ff) begin
               wr_data = rd_data;
               pos_in  = pos_ff - ADDR_W'(1);
               if (pos_ff == ADDR_W'(1)) begin
                  state_in = S_PLACE;
               end
            end else begin
               wr_data      = v_ff;
               count_in     = count_ff + CNT_W'(1);
               sum_in       = sum_ff + SUM_W'(v_ff);
               stat_step_in = '0;
               state_in     = last_ff ? S_STAT : S_IDLE;
            end
         end

         S_PLACE: begin
            wr_en        = 1'b1;
            wr_addr      = pos_ff;
            wr_data      = v_ff;
            count_in     = count_ff + CNT_W'(1);
            sum_in       = sum_ff + SUM_W'(v_ff);
            stat_step_in = '0;
            state_in     = last_ff ? S_STAT : S_IDLE;
         end

         S_STAT: begin
            // Read first, last and both middle entries back to back.
            stat_step_in = stat_step_ff + 3'd1;
            unique case (stat_step_ff)
               3'd0: begin
                  rd_addr = '0;
               end
               3'd1: begin
                  max_in  = rd_data;
                  rd_addr = ADDR_W'(count_ff - CNT_W'(1));
               end
               3'd2: begin
                  min_in  = rd_data;
                  rd_addr = ADDR_W'((count_ff - CNT_W'(1)) >> 1);
               end
               3'd3: begin
                  mid_in  = rd_data;
                  rd_addr = ADDR_W'(count_ff >> 1);
               end
               3'd4: begin
                  median_in   = mid_sum[8:1];
                  rem_in      = '0;
                  num_in      = sum_ff;
                  div_step_in = '0;
                  state_in    = S_DIV;
               end
               default: begin
                  state_in = S_DIV;
               end
            endcase
         end

         S_DIV: begin
            rem_in      = div_ge ? CNT_W'(rem_sh - {1'b0, count_ff}) : rem_sh[CNT_W-1:0];
            num_in      = {num_ff[SUM_W-2:0], div_ge};
            div_step_in = div_step_ff + DIV_W'(1);
            if (div_step_ff == DIV_W'(SUM_W - 1)) begin
               mean_in  = num_in[7:0];
               idx_in   = '0;
               state_in = S_EMIT_RD;
            end
         end

         S_EMIT_RD: begin
            // Read the next entry only when the output register will be free.
            rd_addr = idx_ff;
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_EMIT_LOAD;
            end
         end

         S_EMIT_LOAD: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.sorted_value = rd_data;
            rsp_data_in.minimum      = min_ff;
            rsp_data_in.maximum      = max_ff;
            rsp_data_in.mean         = mean_ff;
            rsp_data_in.median       = median_ff;
            rsp_data_in.overflow     = ovf_ff;
            rsp_data_in.run_end      = emit_last;
            if (emit_last) begin
               count_in = '0;
               sum_in   = '0;
               ovf_in   = 1'b0;
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = S_EMIT_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      v_ff         <= v_in;
      last_ff      <= last_in;
      stat_step_ff <= stat_step_in;
      div_step_ff  <= div_step_in;
      idx_ff       <= idx_in;
      max_ff       <= max_in;
      min_ff       <= min_in;
      mid_ff       <= mid_in;
      median_ff    <= median_in;
      mean_ff      <= mean_in;
      rem_ff       <= rem_in;
      num_ff       <= num_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/sbs_checker.sv =====
// Port-level checker of the sorted byte statistics block and its bind.
`timescale 1ns / 1ps
`default_nettype none

module sbs_checker
   import sbs_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or vanished while stalled");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.minimum <= rsp_data.sorted_value &&
                    rsp_data.sorted_value <= rsp_data.maximum)
      else $error("sorted value outside min/max");

   a_stat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.minimum <= rsp_data.median &&
                    rsp_data.median <= rsp_data.maximum &&
                    rsp_data.minimum <= rsp_data.mean &&
                    rsp_data.mean <= rsp_data.maximum)
      else $error("mean or median outside min/max");

   // No new byte may enter while a run is still being reported.
   a_no_load_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.run_end |=> !req_ready)
      else $error("input accepted in the middle of a run");

endmodule

bind sorted_byte_statistics_core sbs_checker u_sbs_checker (.*);

`default_nettype wire
